// ===== rtl/core/prdp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prdp_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = 2'd3;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned COORD_W = 16;
  localparam logic [SIZE_W-1:0] MAX_FRAME_SIZE = 13'd4096;

  // Depth of the record queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified record, ready to be serialized.
  typedef struct packed {
    logic               hdr;     // record opens a datagram
    logic               dg_end;  // record closes a datagram
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } rec_t;

  // A size of zero acts as one, a size beyond the maximum acts as the maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = {{(SIZE_W-1){1'b0}}, 1'b1};
    end else if (v > MAX_FRAME_SIZE) begin
      r = MAX_FRAME_SIZE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/prdp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pixel request channel.
interface prdp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Datagram byte channel.
interface prdp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       datagram_end;
  logic       run_last;

  modport source (output valid, output out_byte, output datagram_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input datagram_end, input run_last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/prdp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prdp_front #(
  parameter int unsigned RECORDS_PER_DATAGRAM = 160
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [prdp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [prdp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  prdp_pix_if.sink                            pix,
  input  wire logic                           full_i,
  output logic                                push_o,
  output prdp_pkg::rec_t                      rec_o
);
  import prdp_pkg::*;

  localparam int unsigned CW = $clog2(RECORDS_PER_DATAGRAM + 1);
  localparam logic [CW:0] RPD_C = (CW + 1)'(RECORDS_PER_DATAGRAM);

  logic [SIZE_W-1:0]  frame_width_q, frame_height_q;
  logic [COORD_W-1:0] x_offset_q, y_offset_q;
  logic [POS_W-1:0]   col_q, col_d, row_q, row_d;
  logic [CW-1:0]      cnt_q, cnt_d;

  logic [SIZE_W-1:0]  w, h, col_inc, row_inc;
  logic [CW:0]        cnt_inc;
  logic               row_last, frame_last, full, dg_end, accept;

  assign pix.ready = !full_i;
  assign accept    = pix.valid && !full_i;
  assign push_o    = accept;

  always_comb begin
    w          = clamp_size(frame_width_q);
    h          = clamp_size(frame_height_q);
    col_inc    = {1'b0, col_q} + {{(SIZE_W-1){1'b0}}, 1'b1};
    row_inc    = {1'b0, row_q} + {{(SIZE_W-1){1'b0}}, 1'b1};
    row_last   = col_inc >= w;
    frame_last = row_last && (row_inc >= h);
    cnt_inc    = {1'b0, cnt_q} + {{CW{1'b0}}, 1'b1};
    full       = cnt_inc >= RPD_C;
    dg_end     = full || frame_last;

    rec_o.hdr    = (cnt_q == '0);
    rec_o.dg_end = dg_end;
    rec_o.xs     = {{(COORD_W-POS_W){1'b0}}, col_q} + x_offset_q;
    rec_o.ys     = {{(COORD_W-POS_W){1'b0}}, row_q} + y_offset_q;
    rec_o.red    = pix.red;
    rec_o.green  = pix.green;
    rec_o.blue   = pix.blue;

    cnt_d = cnt_q;
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      cnt_d = dg_end ? '0 : cnt_inc[CW-1:0];
      if (frame_last) begin
        col_d = '0;
        row_d = '0;
      end else if (row_last) begin
        col_d = '0;
        row_d = row_inc[POS_W-1:0];
      end else begin
        col_d = col_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 13'd64;
      frame_height_q <= 13'd32;
      x_offset_q     <= '0;
      y_offset_q     <= '0;
      col_q          <= '0;
      row_q          <= '0;
      cnt_q          <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[SIZE_W-1:0];
          CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[SIZE_W-1:0];
          CFG_X_OFFSET:     x_offset_q     <= cfg_data_i[COORD_W-1:0];
          CFG_Y_OFFSET:     y_offset_q     <= cfg_data_i[COORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prdp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prdp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire prdp_pkg::rec_t  rec_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output prdp_pkg::rec_t       head_o
);
  import prdp_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] DEPTH_C = NW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(QUEUE_DEPTH - 1);

  rec_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] num_q;
  logic          do_push, do_pop;

  assign full_o  = (num_q == DEPTH_C);
  assign empty_o = (num_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_C) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_C) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        num_q <= num_q + 1'b1;
      end else if (do_pop && !do_push) begin
        num_q <= num_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prdp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prdp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire prdp_pkg::rec_t  head_i,
  output logic                 pop_o,
  prdp_byte_if.source          dgram
);
  import prdp_pkg::*;

  // Byte positions within a datagram record; the header takes the first two.
  localparam logic [3:0] POS_X_LO  = 4'd2;
  localparam logic [3:0] POS_X_HI  = 4'd3;
  localparam logic [3:0] POS_Y_LO  = 4'd4;
  localparam logic [3:0] POS_Y_HI  = 4'd5;
  localparam logic [3:0] POS_RED   = 4'd6;
  localparam logic [3:0] POS_GREEN = 4'd7;
  localparam logic [3:0] POS_BLUE  = 4'd8;

  logic [3:0] idx_q, idx_d, sel;
  logic       fire;

  always_comb begin
    sel = idx_q + (head_i.hdr ? 4'd0 : POS_X_LO);
    case (sel)
      POS_X_LO:  dgram.out_byte = head_i.xs[7:0];
      POS_X_HI:  dgram.out_byte = head_i.xs[15:8];
      POS_Y_LO:  dgram.out_byte = head_i.ys[7:0];
      POS_Y_HI:  dgram.out_byte = head_i.ys[15:8];
      POS_RED:   dgram.out_byte = head_i.red;
      POS_GREEN: dgram.out_byte = head_i.green;
      POS_BLUE:  dgram.out_byte = head_i.blue;
      default:   dgram.out_byte = 8'h00;
    endcase
    dgram.valid        = !empty_i;
    dgram.run_last     = (sel == POS_BLUE);
    dgram.datagram_end = dgram.run_last && head_i.dg_end;
    fire  = dgram.valid && dgram.ready;
    pop_o = fire && dgram.run_last;
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (fire) begin
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pixel_record_datagram_packer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pixel record datagram packer. Pixels arrive one per request on pix_i in raster
// order, and a column and a row counter walk over the configured frame (sizes of
// zero act as one, sizes above 4096 act as 4096). Each pixel leaves on dgram_o as
// a 7-byte record: column plus x_offset and row plus y_offset, each 16 bits low
// byte first, then red, green and blue. A datagram opens with two zero header
// bytes and closes after RECORDS_PER_DATAGRAM records or at the last pixel of the
// frame; datagram_end marks its final byte and run_last marks the last byte of
// every pixel. The output is one byte per cycle while dgram_o is ready and a
// record is queued; the byte serializer in the back end sets that rate.
// A front end classifies each pixel and a two-entry record queue sits in between,
// so a new pixel is taken while the previous one is still being sent. Write the
// configuration registers only while the block is idle.
module pixel_record_datagram_packer_unit #(
  parameter int unsigned RECORDS_PER_DATAGRAM = 160
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [prdp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [prdp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  prdp_pix_if.sink                            pix_i,
  prdp_byte_if.source                         dgram_o
);
  import prdp_pkg::*;

  // Records handed from the front end to the queue, and from the queue to the
  // serializer.
  rec_t push_rec, head_rec;
  logic push, full, pop, empty;

  prdp_front #(
    .RECORDS_PER_DATAGRAM(RECORDS_PER_DATAGRAM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix        (pix_i),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  prdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_rec)
  );

  // The serializer pops a record only after its last byte is taken.
  prdp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_rec),
    .pop_o   (pop),
    .dgram   (dgram_o)
  );

endmodule

`default_nettype wire
